[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define QWA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define QWA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[hw/rtl/qwa_pkg.sv]
package qwa_pkg;

  localparam int DeltaW    = 32;
  localparam int CoordBits = 32;
  localparam int TurnW     = 32;
  localparam int QuadW     = 2;
  localparam int ProdW     = 2 * DeltaW;

  typedef logic signed [DeltaW-1:0] delta_t;
  typedef logic signed [TurnW-1:0]  turn_t;
  typedef logic [QuadW-1:0]         quad_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  typedef enum logic [QuadW-1:0] {
    STEP_NONE     = 2'd0,
    STEP_PLUS     = 2'd1,
    STEP_OPPOSITE = 2'd2,
    STEP_MINUS    = 2'd3
  } qstep_t;

  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

  typedef struct packed {
    delta_t h;
    delta_t v;
    delta_t prev_h;
    delta_t prev_v;
    quad_t  quad;
    qstep_t step;
    logic   first;
  } s1_t;

  typedef struct packed {
    prod_t  prod_a;
    prod_t  prod_b;
    quad_t  quad;
    qstep_t step;
    logic   first;
  } s2_t;

  function automatic delta_t coord_value(logic [DeltaW-1:0] raw);
    delta_t shifted;
    shifted = $signed(raw << (DeltaW - CoordBits));
    return shifted >>> (DeltaW - CoordBits);
  endfunction

  function automatic quad_t classify(delta_t h, delta_t v);
    quad_t q;
    if (h >= 0 && v > 0) begin
      q = QUAD_0;
    end else if (h > 0 && v <= 0) begin
      q = QUAD_1;
    end else if (h <= 0 && v < 0) begin
      q = QUAD_2;
    end else begin
      q = QUAD_3;
    end
    return q;
  endfunction

endpackage

[hw/rtl/qwa_if.sv]
interface qwa_in_if;
  import qwa_pkg::*;

  logic   valid;
  logic   ready;
  delta_t delta_h;
  delta_t delta_v;
  logic   first_vertex;

  modport source (output valid, output delta_h, output delta_v, output first_vertex,
                  input ready);
  modport sink   (input valid, input delta_h, input delta_v, input first_vertex,
                  output ready);
endinterface

interface qwa_out_if;
  import qwa_pkg::*;

  logic  valid;
  logic  ready;
  turn_t quarter_turns;
  logic  on_boundary;
  quad_t quadrant;

  modport source (output valid, output quarter_turns, output on_boundary, output quadrant,
                  input ready);
  modport sink   (input valid, input quarter_turns, input on_boundary, input quadrant,
                  output ready);
endinterface

[hw/rtl/qwa_front.sv]
module qwa_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qwa_pkg::delta_t in_delta_h,
  input  qwa_pkg::delta_t in_delta_v,
  input  logic           in_first_vertex,
  output logic           s1_valid,
  input  logic           s1_ready,
  output qwa_pkg::s1_t   s1
);
  import qwa_pkg::*;

  logic   s1_valid_r;
  s1_t    s1_r;
  delta_t prev_h_r;
  delta_t prev_v_r;
  quad_t  prev_q_r;
  delta_t h;
  delta_t v;
  quad_t  q;
  logic   accept;

  assign h        = coord_value(in_delta_h);
  assign v        = coord_value(in_delta_v);
  assign q        = classify(h, v);
  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_h_r   <= '0;
      prev_v_r   <= '0;
      prev_q_r   <= QUAD_0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        prev_h_r   <= h;
        prev_v_r   <= v;
        prev_q_r   <= q;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.h      <= h;
      s1_r.v      <= v;
      s1_r.prev_h <= prev_h_r;
      s1_r.prev_v <= prev_v_r;
      s1_r.quad   <= q;
      s1_r.step   <= qstep_t'(quad_t'(q - prev_q_r));
      s1_r.first  <= in_first_vertex;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

[hw/rtl/qwa_cross.sv]
module qwa_cross (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s1_valid,
  output logic         s1_ready,
  input  qwa_pkg::s1_t s1,
  output logic         s2_valid,
  input  logic         s2_ready,
  output qwa_pkg::s2_t s2
);
  import qwa_pkg::*;

  logic s2_valid_r;
  s2_t  s2_r;
  logic load;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      if (load) begin
        s2_valid_r <= 1'b1;
      end else if (s2_ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r.prod_a <= prod_t'(s1.prev_v) * prod_t'(s1.h);
      s2_r.prod_b <= prod_t'(s1.prev_h) * prod_t'(s1.v);
      s2_r.quad   <= s1.quad;
      s2_r.step   <= s1.step;
      s2_r.first  <= s1.first;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

[hw/rtl/qwa_accum.sv]
module qwa_accum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s2_valid,
  output logic            s2_ready,
  input  qwa_pkg::s2_t    s2,
  output logic            out_valid,
  input  logic            out_ready,
  output qwa_pkg::turn_t  out_quarter_turns,
  output logic            out_on_boundary,
  output qwa_pkg::quad_t  out_quadrant
);
  import qwa_pkg::*;

  localparam int SumW = TurnW + 2;

  logic                   out_valid_r;
  turn_t                  turn_r;
  logic                   flag_r;
  quad_t                  quad_r;
  turn_t                  turn_nxt;
  logic                   flag_nxt;
  logic signed [2:0]      step_amt;
  logic signed [SumW-1:0] sum;
  logic                   load;

  assign s2_ready = !out_valid_r || out_ready;
  assign load     = s2_valid && s2_ready;

  always_comb begin
    step_amt = 3'sd0;
    flag_nxt = flag_r;
    case (s2.step)
      STEP_PLUS:  step_amt = 3'sd1;
      STEP_MINUS: step_amt = -3'sd1;
      STEP_OPPOSITE: begin
        if (s2.prod_a < s2.prod_b) begin
          step_amt = 3'sd2;
        end else if (s2.prod_a > s2.prod_b) begin
          step_amt = -3'sd2;
        end else begin
          flag_nxt = 1'b1;
        end
      end
      default: step_amt = 3'sd0;
    endcase

    sum = SumW'(turn_r) + SumW'(step_amt);
    if (sum[SumW-1:TurnW-1] == '0 || sum[SumW-1:TurnW-1] == '1) begin
      turn_nxt = sum[TurnW-1:0];
    end else if (sum[SumW-1]) begin
      turn_nxt = {1'b1, {(TurnW-1){1'b0}}};
    end else begin
      turn_nxt = {1'b0, {(TurnW-1){1'b1}}};
    end

    if (s2.first) begin
      turn_nxt = '0;
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      turn_r      <= '0;
      flag_r      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        turn_r      <= turn_nxt;
        flag_r      <= flag_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quad_r <= s2.quad;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_quarter_turns = turn_r;
  assign out_on_boundary   = flag_r;
  assign out_quadrant      = quad_r;

endmodule

[hw/rtl/quadrant_winding_accumulator_top.sv]
// channel   role   transfer when          payload
// in_ch     sink   valid && ready         delta_h, delta_v, first_vertex
// out_ch    source valid && ready         quarter_turns, on_boundary, quadrant
//
// One vertex per cycle while the output is not stalled; each vertex passes the input
// register and the cross-product register before the result register loads.
// Stages: input register, cross-product register (two 32x32 multiplies),
// count/flag update into the output register.
// Reset (rst_n low, synchronous) clears count, flag and previous vertex.
// A stalled output holds; upstream stages keep filling until all three are full.
`include "assert_macros.svh"

module quadrant_winding_accumulator_top (
  input logic        clk,
  input logic        rst_n,
  qwa_in_if.sink     in_ch,
  qwa_out_if.source  out_ch
);
  import qwa_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2;
  logic acc_load;

  qwa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_delta_h      (in_ch.delta_h),
    .in_delta_v      (in_ch.delta_v),
    .in_first_vertex (in_ch.first_vertex),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1              (s1)
  );

  qwa_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  qwa_accum u_accum (
    .clk               (clk),
    .rst_n             (rst_n),
    .s2_valid          (s2_valid),
    .s2_ready          (s2_ready),
    .s2                (s2),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_quarter_turns (out_ch.quarter_turns),
    .out_on_boundary   (out_ch.on_boundary),
    .out_quadrant      (out_ch.quadrant)
  );

  assign acc_load = s2_valid && s2_ready;

  `QWA_ASSERT(a_count_holds, clk, rst_n, $past(rst_n) && !$past(acc_load) |-> $stable(out_ch.quarter_turns))
  `QWA_ASSERT(a_first_clears, clk, rst_n, acc_load && s2.first |=> out_ch.quarter_turns == '0 && !out_ch.on_boundary)
  `QWA_ASSERT(a_s2_kept, clk, rst_n, s2_valid && !s2_ready |=> s2_valid)
  `QWA_ASSERT(a_flag_rise, clk, rst_n, $past(rst_n) && $rose(out_ch.on_boundary) |-> $past(acc_load) && $past(s2.step) == STEP_OPPOSITE)

endmodule

[verif/quadrant_winding_accumulator_top_test.sv]
module quadrant_winding_accumulator_top_test;
  import qwa_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     RANDOM_ITEMS   = 550;
  localparam int     CALM_AFTER     = 460;
  localparam int     LONG_HOLD      = 40;
  localparam int     DRAIN_CYCLES   = 10;
  localparam longint TURN_HI        = 64'sd2147483647;
  localparam longint TURN_LO        = -64'sd2147483648;
  localparam delta_t COORD_MAX      = {1'b0, {(DeltaW-1){1'b1}}};
  localparam delta_t COORD_MIN      = {1'b1, {(DeltaW-1){1'b0}}};

  typedef struct {
    turn_t turns;
    logic  boundary;
    quad_t quad;
  } winding_result_t;

  class winding_checker;
    quad_t           prev_quad;
    delta_t          prev_h;
    delta_t          prev_v;
    longint          turn_total;
    logic            boundary;
    winding_result_t expected_results[$];
    int              mismatches;

    function new();
      prev_quad  = QUAD_0;
      prev_h     = '0;
      prev_v     = '0;
      turn_total = 0;
      boundary   = 1'b0;
      mismatches = 0;
    endfunction

    function quad_t quadrant_of(delta_t h, delta_t v);
      if (h >= 0 && v > 0) begin
        return QUAD_0;
      end
      if (h > 0 && v <= 0) begin
        return QUAD_1;
      end
      if (h <= 0 && v < 0) begin
        return QUAD_2;
      end
      return QUAD_3;
    endfunction

    function void bump_turns(longint d);
      turn_total = turn_total + d;
      if (turn_total > TURN_HI) begin
        turn_total = TURN_HI;
      end
      if (turn_total < TURN_LO) begin
        turn_total = TURN_LO;
      end
    endfunction

    function void note_vertex(delta_t h, delta_t v, logic first);
      quad_t           q;
      qstep_t          step;
      longint          cross_a;
      longint          cross_b;
      winding_result_t res;
      q = quadrant_of(h, v);
      if (first) begin
        turn_total = 0;
        boundary   = 1'b0;
      end else begin
        step = qstep_t'(q - prev_quad);
        case (step)
          STEP_PLUS:  bump_turns(1);
          STEP_MINUS: bump_turns(-1);
          STEP_OPPOSITE: begin
            cross_a = longint'(prev_v) * longint'(h);
            cross_b = longint'(prev_h) * longint'(v);
            if (cross_a < cross_b) begin
              bump_turns(2);
            end else if (cross_a > cross_b) begin
              bump_turns(-2);
            end else begin
              boundary = 1'b1;
            end
          end
          default: ;
        endcase
      end
      prev_quad    = q;
      prev_h       = h;
      prev_v       = v;
      res.turns    = turn_t'(turn_total);
      res.boundary = boundary;
      res.quad     = q;
      expected_results.push_back(res);
    endfunction

    function void check_result(turn_t turns, logic bnd, quad_t quad);
      winding_result_t res;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: turns=%0d boundary=%0b quadrant=%0d", turns, bnd, quad);
        end
        return;
      end
      res = expected_results.pop_front();
      if (res.turns !== turns || res.boundary !== bnd || res.quad !== quad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected turns=%0d boundary=%0b quadrant=%0d, got turns=%0d boundary=%0b quadrant=%0d",
                   res.turns, res.boundary, res.quad, turns, bnd, quad);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qwa_in_if  in_ch();
  qwa_out_if out_ch();

  quadrant_winding_accumulator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  winding_checker sb = new();

  int   vertices_taken = 0;
  int   quiet_cycles   = 0;
  bit   idling         = 1'b1;
  bit   long_pending   = 1'b1;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_vertex(in_ch.delta_h, in_ch.delta_v, in_ch.first_vertex);
      vertices_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.quarter_turns, out_ch.on_boundary, out_ch.quadrant);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: short random stalls, one long hold-off to back up the pipeline
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_pending && vertices_taken >= 100) begin
        out_ch.ready <= 1'b0;
        hold_left    = LONG_HOLD - 1;
        long_pending = 1'b0;
      end else if (idling && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        hold_left    = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_vertex(delta_t h, delta_t v, logic first);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.delta_h      <= h;
    in_ch.delta_v      <= v;
    in_ch.first_vertex <= first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic delta_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2: return delta_t'(int'($urandom_range(0, 6)) - 3);
      3, 4, 5, 6: return delta_t'($urandom);
      7: return COORD_MAX;
      8: return COORD_MIN;
      default: return delta_t'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // place a point strictly by the quadrant rules; the near axis may be zero
  task automatic point_in_quad(quad_t q, output delta_t h, output delta_t v);
    delta_t near_mag;
    delta_t far_mag;
    near_mag = delta_t'($urandom_range(0, 1 << $urandom_range(0, 30)));
    far_mag  = delta_t'($urandom_range(1, 1 << $urandom_range(1, 30)));
    case (q)
      QUAD_0: begin
        h = near_mag;
        v = far_mag;
      end
      QUAD_1: begin
        h = far_mag;
        v = -near_mag;
      end
      QUAD_2: begin
        h = -near_mag;
        v = -far_mag;
      end
      default: begin
        h = -far_mag;
        v = near_mag;
      end
    endcase
  endtask

  task automatic send_polygon(ref int sent);
    delta_t start_h;
    delta_t start_v;
    int     n;
    start_h = pick_coord();
    start_v = pick_coord();
    send_vertex(start_h, start_v, 1'b1);
    n = $urandom_range(2, 10);
    repeat (n) send_vertex(pick_coord(), pick_coord(), 1'b0);
    send_vertex(start_h, start_v, 1'b0);
    sent += n + 2;
  endtask

  task automatic send_winding_loop(ref int sent);
    delta_t start_h;
    delta_t start_v;
    delta_t h;
    delta_t v;
    quad_t  q;
    quad_t  dir;
    int     steps;
    q     = quad_t'($urandom_range(0, 3));
    dir   = $urandom_range(0, 1) ? QUAD_1 : QUAD_3;
    steps = 4 * $urandom_range(1, 3);
    point_in_quad(q, start_h, start_v);
    send_vertex(start_h, start_v, 1'b1);
    for (int i = 1; i < steps; i++) begin
      q = q + dir;
      if ($urandom_range(0, 5) == 0) begin
        q = q + dir;
        i++;
      end
      point_in_quad(q, h, v);
      send_vertex(h, v, 1'b0);
    end
    send_vertex(start_h, start_v, 1'b0);
    sent += steps + 1;
  endtask

  task automatic send_noise(ref int sent);
    int n;
    n = $urandom_range(3, 12);
    repeat (n) send_vertex(pick_coord(), pick_coord(), $urandom_range(0, 4) == 0);
    sent += n;
  endtask

  initial begin
    int sent;
    sent               = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.delta_h      = '0;
    in_ch.delta_v      = '0;
    in_ch.first_vertex = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // origin with no polygon start, against the reset previous vertex
    send_vertex(0, 0, 1'b0);
    // one loop around, then closing vertex
    send_vertex(5, 7, 1'b1);
    send_vertex(7, -5, 1'b0);
    send_vertex(-5, -7, 1'b0);
    send_vertex(-7, 5, 1'b0);
    send_vertex(5, 7, 1'b0);
    // opposite jump through the test point, then keep counting
    send_vertex(-5, -7, 1'b0);
    send_vertex(7, -5, 1'b0);
    // opposite jumps of both senses
    send_vertex(-3, 4, 1'b0);
    send_vertex(2, -9, 1'b0);
    send_vertex(-9, 1, 1'b0);
    // field extremes
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(0, COORD_MIN, 1'b0);
    send_vertex(0, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, 0, 1'b0);
    send_vertex(COORD_MAX, 0, 1'b0);
    // axis points
    send_vertex(0, 1, 1'b1);
    send_vertex(1, 0, 1'b0);
    send_vertex(0, -1, 1'b0);
    send_vertex(-1, 0, 1'b0);
    send_vertex(0, 1, 1'b0);

    while (sent < RANDOM_ITEMS) begin
      if (sent >= CALM_AFTER) begin
        idling = 1'b0;
      end else begin
        idling = $urandom_range(0, 7) != 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_polygon(sent);
        5, 6, 7:       send_winding_loop(sent);
        default:       send_noise(sent);
      endcase
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
